/* design/vcts_pkg.sv */
// Package: shared types and constants for the VCO coarse-tune search.
`default_nettype none
package vcts_pkg;

    localparam int CODE_W = 8;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_MEASURE = 1'b1
    } t_opcode;

    localparam logic [CODE_W-1:0] CODE_PROBE_LO = 8'd63;
    localparam logic [CODE_W-1:0] CODE_PROBE_HI = 8'd64;
    localparam logic [CODE_W-1:0] BASE_LOW      = 8'd16;
    localparam logic [CODE_W-1:0] BASE_MID      = 8'd48;
    localparam logic [CODE_W-1:0] BASE_HIGH     = 8'd80;
    localparam logic [6:0]        CENTRE_LOW    = 7'd32;
    localparam logic [6:0]        CENTRE_MID    = 7'd64;
    localparam logic [6:0]        CENTRE_HIGH   = 7'd96;
    localparam logic [CODE_W-1:0] SEG_SPAN      = 8'd32;
    localparam logic [3:0]        STEP_INIT     = 4'd8;
    localparam logic [CODE_W-1:0] BEST_CT_RESET = 8'd77;

    typedef struct packed {
        logic [CODE_W-1:0] next_code;
        logic              finished;
        logic [CODE_W-1:0] best_code;
        logic              ignored;
    } t_result;

    typedef struct packed {
        logic [CODE_W-1:0] base;
        logic [6:0]        centre;
    } t_segment;

endpackage
`default_nettype wire

/* design/vcts_if.sv */
// Interfaces: input and result channels of the coarse-tune search.
`default_nettype none
interface vcts_in_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   locked;
    logic [SAMPLE_BITS-1:0] offset;

    modport source (output valid, opcode, sample, locked, offset, input ready);
    modport sink   (input valid, opcode, sample, locked, offset, output ready);
endinterface

interface vcts_out_if import vcts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] next_code;
    logic              finished;
    logic [CODE_W-1:0] best_code;
    logic              ignored;

    modport source (output valid, next_code, finished, best_code, ignored, input ready);
    modport sink   (input valid, next_code, finished, best_code, ignored, output ready);
endinterface
`default_nettype wire

/* design/vco_coarse_tune_search.sv */
// Top level: VCO coarse-tune search sequencer with registered result and skid stage.
`default_nettype none
// Channel  Dir  Handshake          Payload
// i_in     in   valid/ready        opcode, sample, locked, offset
// o_out    out  valid/ready        next_code, finished, best_code, ignored
//
// One result beat per input beat, registered after acceptance; one beat a cycle while o_out does not stall.
// Search state updates in the accept cycle; the result lands in the output register.
// A skid register holds one more result while o_out stalls; i_in.ready drops only
// when both are full.
// Synchronous active-low reset: idle, best code 77, both result slots empty.
module vco_coarse_tune_search import vcts_pkg::*; #(
    parameter int SAMPLE_BITS = 12,
    parameter int SA_STEPS    = 6
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    vcts_in_if.sink       i_in,
    vcts_out_if.source    o_out
);

    localparam int PH_W = $clog2(SA_STEPS + 2);
    localparam logic [PH_W-1:0] PH_PROBE_LO = PH_W'(0);
    localparam logic [PH_W-1:0] PH_PROBE_HI = PH_W'(1);
    localparam logic [PH_W-1:0] PH_SA_FIRST = PH_W'(2);
    localparam logic [PH_W-1:0] PH_SA_LAST  = PH_W'(SA_STEPS + 1);
    localparam logic [SAMPLE_BITS-1:0] ERR_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // search state
    logic                   r_busy, n_busy;
    logic [PH_W-1:0]        r_phase, n_phase;
    logic [SAMPLE_BITS-1:0] r_ref_offset, n_ref_offset;
    logic [SAMPLE_BITS-1:0] r_volt_63, n_volt_63;
    logic [SAMPLE_BITS-1:0] r_volt_64, n_volt_64;
    logic                   r_segment, n_segment;
    logic [CODE_W-1:0]      r_cur_code, n_cur_code;
    logic [3:0]             r_step, n_step;
    logic [6:0]             r_centre, n_centre;
    logic [SAMPLE_BITS-1:0] r_min_err, n_min_err;
    logic [CODE_W-1:0]      r_seg_best, n_seg_best;
    logic [CODE_W-1:0]      r_seg_dist, n_seg_dist;
    logic [CODE_W-1:0]      r_best_dist, n_best_dist;
    logic [CODE_W-1:0]      r_best_ct, n_best_ct;

    // result slots
    t_result r_out, r_skid, res;
    logic    r_out_vld, r_skid_vld;

    logic                   acc, take;
    logic [SAMPLE_BITS-1:0] err;
    logic [CODE_W-1:0]      centre_ext;
    t_segment               seg;

    // Segment pick: both probes below offset -> high band, both above -> low band.
    function automatic t_segment pick_segment(
        input logic [SAMPLE_BITS-1:0] v63,
        input logic [SAMPLE_BITS-1:0] v64,
        input logic [SAMPLE_BITS-1:0] off,
        input logic                   second
    );
        t_segment s;
        s.base   = BASE_MID;
        s.centre = CENTRE_MID;
        if (v63 < off && v64 < off) begin
            s.base   = BASE_HIGH;
            s.centre = CENTRE_HIGH;
        end
        if (v63 > off && v64 > off) begin
            s.base   = BASE_LOW;
            s.centre = CENTRE_LOW;
        end
        if (second) begin
            s.base = s.base + SEG_SPAN;
        end
        return s;
    endfunction

    assign i_in.ready = !r_skid_vld;
    assign acc        = i_in.valid && !r_skid_vld;
    assign take       = r_out_vld && o_out.ready;

    always_comb begin
        n_busy       = r_busy;
        n_phase      = r_phase;
        n_ref_offset = r_ref_offset;
        n_volt_63    = r_volt_63;
        n_volt_64    = r_volt_64;
        n_segment    = r_segment;
        n_cur_code   = r_cur_code;
        n_step       = r_step;
        n_centre     = r_centre;
        n_min_err    = r_min_err;
        n_seg_best   = r_seg_best;
        n_seg_dist   = r_seg_dist;
        n_best_dist  = r_best_dist;
        n_best_ct    = r_best_ct;
        res          = '0;
        seg          = '0;
        err          = (i_in.sample >= r_ref_offset) ? i_in.sample - r_ref_offset
                                                     : r_ref_offset - i_in.sample;
        centre_ext   = {1'b0, r_centre};

        if (i_in.opcode == OP_START) begin
            // start, or restart mid-search; best code survives
            n_busy        = 1'b1;
            n_phase       = PH_PROBE_LO;
            n_ref_offset  = i_in.offset;
            n_segment     = 1'b0;
            n_step        = STEP_INIT;
            n_min_err     = ERR_INIT;
            n_seg_best    = '0;
            n_seg_dist    = '0;
            n_best_dist   = '0;
            res.next_code = CODE_PROBE_LO;
        end else if (!r_busy) begin
            res.ignored = 1'b1;
        end else if (r_phase == PH_PROBE_LO) begin
            n_volt_63     = i_in.sample;
            n_phase       = PH_PROBE_HI;
            res.next_code = CODE_PROBE_HI;
        end else if (r_phase == PH_PROBE_HI) begin
            n_volt_64     = i_in.sample;
            n_segment     = 1'b0;
            seg           = pick_segment(r_volt_63, i_in.sample, r_ref_offset, 1'b0);
            n_cur_code    = seg.base;
            n_centre      = seg.centre;
            n_step        = STEP_INIT;
            n_min_err     = ERR_INIT;
            n_phase       = PH_SA_FIRST;
            res.next_code = seg.base;
        end else begin
            // one SA step; error tracking only on locked samples
            if (i_in.locked && err < r_min_err) begin
                n_min_err  = err;
                n_seg_best = r_cur_code;
                n_seg_dist = (r_cur_code > centre_ext) ? r_cur_code - centre_ext
                                                       : centre_ext - r_cur_code;
            end
            if (i_in.sample < r_ref_offset) begin
                n_cur_code = r_cur_code + {4'd0, r_step};
            end else begin
                n_cur_code = r_cur_code - {4'd0, r_step};
            end
            if (r_step > 4'd1) begin
                n_step = r_step >> 1;
            end

            if (r_phase >= PH_SA_LAST) begin
                n_min_err = ERR_INIT;
                if (n_seg_dist > r_best_dist) begin
                    n_best_dist = n_seg_dist;
                    n_best_ct   = n_seg_best;
                end
                if (!r_segment) begin
                    n_segment     = 1'b1;
                    seg           = pick_segment(r_volt_63, r_volt_64, r_ref_offset, 1'b1);
                    n_cur_code    = seg.base;
                    n_centre      = seg.centre;
                    n_step        = STEP_INIT;
                    n_phase       = PH_SA_FIRST;
                    res.next_code = seg.base;
                end else begin
                    n_busy        = 1'b0;
                    n_phase       = PH_PROBE_LO;
                    res.finished  = 1'b1;
                    res.next_code = n_best_ct;
                end
            end else begin
                n_phase       = r_phase + PH_W'(1);
                res.next_code = n_cur_code;
            end
        end
        res.best_code = n_best_ct;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_phase      <= PH_PROBE_LO;
            r_ref_offset <= '0;
            r_volt_63    <= '0;
            r_volt_64    <= '0;
            r_segment    <= 1'b0;
            r_cur_code   <= '0;
            r_step       <= STEP_INIT;
            r_centre     <= '0;
            r_min_err    <= ERR_INIT;
            r_seg_best   <= '0;
            r_seg_dist   <= '0;
            r_best_dist  <= '0;
            r_best_ct    <= BEST_CT_RESET;
        end else if (acc) begin
            r_busy       <= n_busy;
            r_phase      <= n_phase;
            r_ref_offset <= n_ref_offset;
            r_volt_63    <= n_volt_63;
            r_volt_64    <= n_volt_64;
            r_segment    <= n_segment;
            r_cur_code   <= n_cur_code;
            r_step       <= n_step;
            r_centre     <= n_centre;
            r_min_err    <= n_min_err;
            r_seg_best   <= n_seg_best;
            r_seg_dist   <= n_seg_dist;
            r_best_dist  <= n_best_dist;
            r_best_ct    <= n_best_ct;
        end
    end

    // Output register plus skid: skid only fills while the output holds a stalled beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= acc;
            end
        end else if (acc) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_vld) begin
            r_out <= r_skid_vld ? r_skid : res;
        end
        if (acc && r_out_vld && !take) begin
            r_skid <= res;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.next_code = r_out.next_code;
    assign o_out.finished  = r_out.finished;
    assign o_out.best_code = r_out.best_code;
    assign o_out.ignored   = r_out.ignored;

endmodule
`default_nettype wire

/* design/vcts_checker.sv */
// Checker: port-level assertions for the coarse-tune search, bound to the top level.
`default_nettype none
module vcts_checker import vcts_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [CODE_W-1:0] i_next_code,
    input wire              i_finished,
    input wire [CODE_W-1:0] i_best_code,
    input wire              i_ignored
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_code)
        && $stable(i_finished) && $stable(i_best_code) && $stable(i_ignored))
        else $error("result beat changed while stalled");

    // input only backs up behind a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    // completion beat programs the final best code
    a_finish_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_finished |-> i_next_code == i_best_code && !i_ignored)
        else $error("finish beat with next code not the best code");

    // idle measurement leaves no code to program
    a_ignored_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ignored |-> i_next_code == '0 && !i_finished)
        else $error("ignored beat carries a code");

endmodule

bind vco_coarse_tune_search vcts_checker u_vcts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_next_code (o_out.next_code),
    .i_finished  (o_out.finished),
    .i_best_code (o_out.best_code),
    .i_ignored   (o_out.ignored)
);
`default_nettype wire
